/* rtl/core/kvt_pkg.sv */
// Package for the keyed value table: request op codes, field widths and defaults.
// Used by keyed_value_table_core; depends on nothing else.
`default_nettype none

package kvt_pkg;

  localparam int DEF_CAPACITY = 16;

  localparam int KEY_W   = 32;
  localparam int VALUE_W = 64;
  localparam int OP_W    = 2;
  localparam int COUNT_W = 5;

  typedef enum logic [OP_W-1:0] {
    OP_STORE  = 2'd0,
    OP_READ   = 2'd1,
    OP_DELETE = 2'd2,
    OP_EXISTS = 2'd3
  } op_t;

endpackage

`default_nettype wire

/* rtl/core/keyed_value_table_core.sv */
// Keyed value table core: a CAPACITY-entry key/value store searched by one shared comparator.
// Depends on kvt_pkg for op codes, field widths and the default capacity.
`default_nettype none

//  Channel   Ports                                          Handshake
//  request   in_op, in_key, in_value                        start high while busy low
//  result    out_read_value, out_found, out_full_error,     out_valid, one cycle, no stall
//            out_entry_count
//
// The result beat follows the scan, ST_EXEC and ST_RESP in that order: the single comparator
// walks one entry per cycle behind the registered key read, ST_EXEC updates the tables and
// ST_RESP registers the result. The next request can be taken at the edge that ends the beat.
// Reset (rst_n low, synchronous) clears the state, the valid bits, the entry count and the compare and result valids.
// busy is high until the result beat is on the ports; the receiver cannot hold it off.

module keyed_value_table_core #(
  parameter int CAPACITY = kvt_pkg::DEF_CAPACITY
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,

  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [kvt_pkg::OP_W-1:0]    in_op,
  input  wire logic [kvt_pkg::KEY_W-1:0]   in_key,
  input  wire logic [kvt_pkg::VALUE_W-1:0] in_value,

  output logic                             out_valid,
  output logic [kvt_pkg::VALUE_W-1:0]      out_read_value,
  output logic                             out_found,
  output logic                             out_full_error,
  output logic [kvt_pkg::COUNT_W-1:0]      out_entry_count
);

  // The index addresses one entry; the count must also be able to hold CAPACITY itself.
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EXEC,
    ST_RESP
  } state_t;

  state_t                         state_r;

  // Latched request.
  kvt_pkg::op_t                   op_r;
  logic [kvt_pkg::KEY_W-1:0]      key_r;
  logic [kvt_pkg::VALUE_W-1:0]    value_r;

  // Scan sequencer: the read pointer runs one entry ahead of the compare pointer,
  // since the key memory has a registered read port.
  logic [CNT_W-1:0]               rd_idx_r;
  logic                           cmp_vld_r;
  logic [IDX_W-1:0]               cmp_idx_r;

  // Search results.
  logic                           hit_r;
  logic [IDX_W-1:0]               hit_idx_r;
  logic                           free_r;
  logic [IDX_W-1:0]               free_idx_r;
  logic                           full_r;

  logic [CAPACITY-1:0]            slot_valid_r;
  logic [CNT_W-1:0]               count_r;

  // Memories and their registered read data.
  logic [kvt_pkg::KEY_W-1:0]      slot_key [CAPACITY];
  logic [kvt_pkg::VALUE_W-1:0]    slot_value [CAPACITY];
  logic [kvt_pkg::KEY_W-1:0]      key_rd_r;
  logic [kvt_pkg::VALUE_W-1:0]    val_rd_r;

  // Registered result beat.
  logic                           out_valid_r;
  logic [kvt_pkg::VALUE_W-1:0]    out_read_value_r;
  logic                           out_found_r;
  logic                           out_full_error_r;
  logic [kvt_pkg::COUNT_W-1:0]    out_entry_count_r;

  logic                           accept;
  logic                           rd_in_range;
  logic [IDX_W-1:0]               key_rd_addr;
  logic                           key_match;
  logic                           store_new;
  logic                           key_we;
  logic                           val_we;
  logic [IDX_W-1:0]               val_addr;
  logic [CNT_W+kvt_pkg::COUNT_W-1:0] count_ext;

  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r != ST_IDLE);

  // Reads beyond the last entry are parked on entry zero and never compared.
  assign rd_in_range = (rd_idx_r < CNT_W'(CAPACITY));
  assign key_rd_addr = rd_in_range ? rd_idx_r[IDX_W-1:0] : '0;

  // The shared comparator: one stored key against the request key per cycle.
  assign key_match = cmp_vld_r && slot_valid_r[cmp_idx_r] && (key_rd_r == key_r);

  // A store of an absent key lands in the lowest free entry, if there is one.
  assign store_new = (state_r == ST_EXEC) && (op_r == kvt_pkg::OP_STORE) && !hit_r && free_r;
  assign key_we    = store_new;
  assign val_we    = store_new ||
                     ((state_r == ST_EXEC) && (op_r == kvt_pkg::OP_STORE) && hit_r);
  assign val_addr  = hit_r ? hit_idx_r : free_idx_r;

  // The entry count is shown modulo 32, as its five output bits allow.
  assign count_ext = (CNT_W + kvt_pkg::COUNT_W)'(count_r);

  always_ff @(posedge clk) begin
    if (key_we) begin
      slot_key[free_idx_r] <= key_r;
    end
    key_rd_r <= slot_key[key_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (val_we) begin
      slot_value[val_addr] <= value_r;
    end
    val_rd_r <= slot_value[val_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r           <= ST_IDLE;
      slot_valid_r      <= '0;
      count_r           <= '0;
      cmp_vld_r         <= 1'b0;
      out_valid_r       <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            op_r      <= kvt_pkg::op_t'(in_op);
            key_r     <= in_key;
            value_r   <= in_value;
            rd_idx_r  <= '0;
            cmp_vld_r <= 1'b0;
            hit_r     <= 1'b0;
            free_r    <= 1'b0;
            full_r    <= 1'b0;
            state_r   <= ST_SCAN;
          end
        end

        ST_SCAN: begin
          // Issue the next key read while comparing the one read last cycle.
          if (rd_in_range) begin
            cmp_idx_r <= rd_idx_r[IDX_W-1:0];
            cmp_vld_r <= 1'b1;
            rd_idx_r  <= rd_idx_r + CNT_W'(1);
          end else begin
            cmp_vld_r <= 1'b0;
          end
          if (key_match && !hit_r) begin
            hit_r     <= 1'b1;
            hit_idx_r <= cmp_idx_r;
          end
          if (cmp_vld_r && !slot_valid_r[cmp_idx_r] && !free_r) begin
            free_r     <= 1'b1;
            free_idx_r <= cmp_idx_r;
          end
          if (cmp_vld_r && (cmp_idx_r == IDX_W'(CAPACITY - 1))) begin
            state_r <= ST_EXEC;
          end
        end

        ST_EXEC: begin
          // Table updates happen here; a read of a present key is issued on the value port.
          if (store_new) begin
            slot_valid_r[free_idx_r] <= 1'b1;
            count_r                  <= count_r + CNT_W'(1);
          end
          if ((op_r == kvt_pkg::OP_STORE) && !hit_r && !free_r) begin
            full_r <= 1'b1;
          end
          if ((op_r == kvt_pkg::OP_DELETE) && hit_r) begin
            slot_valid_r[hit_idx_r] <= 1'b0;
            count_r                 <= count_r - CNT_W'(1);
          end
          state_r <= ST_RESP;
        end

        ST_RESP: begin
          out_valid_r       <= 1'b1;
          out_read_value_r  <= ((op_r == kvt_pkg::OP_READ) && hit_r) ? val_rd_r : '0;
          out_found_r       <= hit_r;
          out_full_error_r  <= full_r;
          out_entry_count_r <= count_ext[kvt_pkg::COUNT_W-1:0];
          state_r           <= ST_IDLE;
        end

        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_read_value  = out_read_value_r;
  assign out_found       = out_found_r;
  assign out_full_error  = out_full_error_r;
  assign out_entry_count = out_entry_count_r;

  // A full-table error only arises when the key was absent.
  a_full_not_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_full_error && out_found))
    else $error("full error reported for a key that was present");

  // The entry count never exceeds the table size.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  // An accepted request makes the block busy on the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request accepted but block not busy");

  // The result beat appears exactly as the block becomes ready again.
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!busy && !$past(out_valid)))
    else $error("result beat while busy or longer than one cycle");

endmodule

`default_nettype wire
